@@ src/csrc_pkg.sv @@
// shared types and constants for the single-rectangle clip check
// no dependencies

package csrc_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BAND  = 2'd1,
    MODE_SPAN  = 2'd2,
    MODE_END   = 2'd3
  } mode_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
  } item_ctl_t;

endpackage

@@ src/csrc_in_reg.sv @@
// input register stage for the clip check
// depends on csrc_pkg

module csrc_in_reg #(
  parameter int COORD_WIDTH = csrc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [1:0]                    s_mode,
  input  logic signed [COORD_WIDTH-1:0] s_low_x,
  input  logic signed [COORD_WIDTH-1:0] s_low_y,
  input  logic signed [COORD_WIDTH-1:0] s_high_x,
  input  logic signed [COORD_WIDTH-1:0] s_high_y,
  input  logic                          take,
  output csrc_pkg::item_ctl_t           item_ctl,
  output logic signed [COORD_WIDTH-1:0] low_x,
  output logic signed [COORD_WIDTH-1:0] low_y,
  output logic signed [COORD_WIDTH-1:0] high_x,
  output logic signed [COORD_WIDTH-1:0] high_y
);

  logic            valid;
  csrc_pkg::mode_t mode;
  logic            accept;

  assign s_tready = !valid || take;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept || (valid && !take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode   <= csrc_pkg::mode_t'(s_mode);
      low_x  <= s_low_x;
      low_y  <= s_low_y;
      high_x <= s_high_x;
      high_y <= s_high_y;
    end
  end

  assign item_ctl.valid = valid;
  assign item_ctl.mode  = mode;

endmodule

@@ src/csrc_core.sv @@
// clamp and merge logic with the running clip state
// depends on csrc_pkg

module csrc_core #(
  parameter int COORD_WIDTH = csrc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  csrc_pkg::item_ctl_t           item_ctl,
  input  logic signed [COORD_WIDTH-1:0] low_x,
  input  logic signed [COORD_WIDTH-1:0] low_y,
  input  logic signed [COORD_WIDTH-1:0] high_x,
  input  logic signed [COORD_WIDTH-1:0] high_y,
  output logic                          take,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic                          res_status,
  output logic signed [COORD_WIDTH-1:0] res_lox,
  output logic signed [COORD_WIDTH-1:0] res_loy,
  output logic signed [COORD_WIDTH-1:0] res_hix,
  output logic signed [COORD_WIDTH-1:0] res_hiy
);

  logic signed [COORD_WIDTH-1:0] r_lox, r_loy, r_hix, r_hiy;
  logic signed [COORD_WIDTH-1:0] b_y0, b_y1;
  logic signed [COORD_WIDTH-1:0] m_lox, m_loy, m_hix, m_hiy;
  logic                          failed;

  logic signed [COORD_WIDTH-1:0] r_lox_next, r_loy_next, r_hix_next, r_hiy_next;
  logic signed [COORD_WIDTH-1:0] b_y0_next, b_y1_next;
  logic signed [COORD_WIDTH-1:0] m_lox_next, m_loy_next, m_hix_next, m_hiy_next;
  logic                          failed_next;

  logic                          fire;
  logic signed [COORD_WIDTH-1:0] x0, x1;

  assign take = (item_ctl.mode != csrc_pkg::MODE_END) || res_ready;
  assign fire = item_ctl.valid && take;

  // span clamped to the render rect
  assign x0 = (low_x < r_lox) ? r_lox : low_x;
  assign x1 = (high_x > r_hix) ? r_hix : high_x;

  always_comb begin
    r_lox_next  = r_lox;
    r_loy_next  = r_loy;
    r_hix_next  = r_hix;
    r_hiy_next  = r_hiy;
    b_y0_next   = b_y0;
    b_y1_next   = b_y1;
    m_lox_next  = m_lox;
    m_loy_next  = m_loy;
    m_hix_next  = m_hix;
    m_hiy_next  = m_hiy;
    failed_next = failed;
    if (fire) begin
      case (item_ctl.mode)
        csrc_pkg::MODE_START: begin
          r_lox_next  = low_x;
          r_loy_next  = low_y;
          r_hix_next  = high_x;
          r_hiy_next  = high_y;
          m_lox_next  = low_x;
          m_loy_next  = low_y;
          m_hix_next  = low_x;
          m_hiy_next  = low_y;
          b_y0_next   = low_y;
          b_y1_next   = low_y;
          failed_next = 1'b0;
        end
        csrc_pkg::MODE_BAND: begin
          b_y0_next = (low_y < r_loy) ? r_loy : low_y;
          b_y1_next = (high_y > r_hiy) ? r_hiy : high_y;
        end
        csrc_pkg::MODE_SPAN: begin
          if (!failed && (x0 < x1) && (b_y0 < b_y1)) begin
            if (m_loy == m_hiy) begin
              m_lox_next = x0;
              m_loy_next = b_y0;
              m_hix_next = x1;
              m_hiy_next = b_y1;
            end else if (m_lox == x0 && m_hix == x1 && m_loy <= b_y1 && m_hiy >= b_y0) begin
              if (b_y0 < m_loy) m_loy_next = b_y0;
              if (b_y1 > m_hiy) m_hiy_next = b_y1;
            end else if (m_loy == b_y0 && m_hiy == b_y1 && m_lox <= x1 && m_hix >= x0) begin
              if (x0 < m_lox) m_lox_next = x0;
              if (x1 > m_hix) m_hix_next = x1;
            end else begin
              failed_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_lox  <= '0;
      r_loy  <= '0;
      r_hix  <= '0;
      r_hiy  <= '0;
      b_y0   <= '0;
      b_y1   <= '0;
      m_lox  <= '0;
      m_loy  <= '0;
      m_hix  <= '0;
      m_hiy  <= '0;
      failed <= 1'b0;
    end else begin
      r_lox  <= r_lox_next;
      r_loy  <= r_loy_next;
      r_hix  <= r_hix_next;
      r_hiy  <= r_hiy_next;
      b_y0   <= b_y0_next;
      b_y1   <= b_y1_next;
      m_lox  <= m_lox_next;
      m_loy  <= m_loy_next;
      m_hix  <= m_hix_next;
      m_hiy  <= m_hiy_next;
      failed <= failed_next;
    end
  end

  assign res_valid  = fire && (item_ctl.mode == csrc_pkg::MODE_END);
  assign res_status = failed;
  assign res_lox    = failed ? '0 : m_lox;
  assign res_loy    = failed ? '0 : m_loy;
  assign res_hix    = failed ? '0 : m_hix;
  assign res_hiy    = failed ? '0 : m_hiy;

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item_ctl.mode == csrc_pkg::MODE_START |=> !failed)
    else $error("failed flag not cleared by start word");

  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    failed && !(fire && item_ctl.mode == csrc_pkg::MODE_START) |=> failed)
    else $error("failed flag dropped without start word");

  a_merged_ordered: assert property (@(posedge clk) disable iff (rst)
    m_lox <= m_hix && m_loy <= m_hiy)
    else $error("merged rectangle bounds out of order");

  a_result_needs_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_ready)
    else $error("result issued while output register busy");

endmodule

@@ src/csrc_out_reg.sv @@
// result register stage for the clip check
// depends on csrc_pkg for the default width

module csrc_out_reg #(
  parameter int COORD_WIDTH = csrc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_valid,
  output logic                          res_ready,
  input  logic                          res_status,
  input  logic signed [COORD_WIDTH-1:0] res_lox,
  input  logic signed [COORD_WIDTH-1:0] res_loy,
  input  logic signed [COORD_WIDTH-1:0] res_hix,
  input  logic signed [COORD_WIDTH-1:0] res_hiy,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          status,
  output logic signed [COORD_WIDTH-1:0] vis_lox,
  output logic signed [COORD_WIDTH-1:0] vis_loy,
  output logic signed [COORD_WIDTH-1:0] vis_hix,
  output logic signed [COORD_WIDTH-1:0] vis_hiy
);

  logic valid;

  assign res_ready = !valid || m_tready;
  assign m_tvalid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      status  <= res_status;
      vis_lox <= res_lox;
      vis_loy <= res_loy;
      vis_hix <= res_hix;
      vis_hiy <= res_hiy;
    end
  end

endmodule

@@ src/clip_span_single_rect_check.sv @@
// top level of the single-rectangle clip check
// depends on csrc_pkg, csrc_in_reg, csrc_core, csrc_out_reg

// Accepts one word per cycle: a start word with the render rect, then y bands
// and x spans, then an end word that yields one result word through the input and output registers.
// Each band and span is clamped to the render rect and merged into a running
// rectangle; any shape that is not a single rectangle sets status. Throughput
// is one word per clock; only an end word waits, for as long as the output
// register still holds an untaken result.

module clip_span_single_rect_check #(
  parameter int COORD_WIDTH = csrc_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // low_x, low_y, high_x, high_y, zero padding
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // mode
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // vis_lox, vis_loy, vis_hix, vis_hiy, zero padding
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // status
  output logic                               m_tuser
);

  localparam int DataWidth = ((4*COORD_WIDTH+7)/8)*8;

  csrc_pkg::item_ctl_t           item_ctl;
  logic signed [COORD_WIDTH-1:0] low_x, low_y, high_x, high_y;
  logic                          take;
  logic                          res_valid, res_ready, res_status;
  logic signed [COORD_WIDTH-1:0] res_lox, res_loy, res_hix, res_hiy;
  logic signed [COORD_WIDTH-1:0] vis_lox, vis_loy, vis_hix, vis_hiy;

  csrc_in_reg #(.COORD_WIDTH(COORD_WIDTH)) u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_mode   (s_tuser),
    .s_low_x  (s_tdata[COORD_WIDTH-1:0]),
    .s_low_y  (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .s_high_x (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .s_high_y (s_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
    .take     (take),
    .item_ctl (item_ctl),
    .low_x    (low_x),
    .low_y    (low_y),
    .high_x   (high_x),
    .high_y   (high_y)
  );

  csrc_core #(.COORD_WIDTH(COORD_WIDTH)) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_ctl   (item_ctl),
    .low_x      (low_x),
    .low_y      (low_y),
    .high_x     (high_x),
    .high_y     (high_y),
    .take       (take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res_status (res_status),
    .res_lox    (res_lox),
    .res_loy    (res_loy),
    .res_hix    (res_hix),
    .res_hiy    (res_hiy)
  );

  csrc_out_reg #(.COORD_WIDTH(COORD_WIDTH)) u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_lox    (res_lox),
    .res_loy    (res_loy),
    .res_hix    (res_hix),
    .res_hiy    (res_hiy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .status     (m_tuser),
    .vis_lox    (vis_lox),
    .vis_loy    (vis_loy),
    .vis_hix    (vis_hix),
    .vis_hiy    (vis_hiy)
  );

  assign m_tdata = DataWidth'({vis_hiy, vis_hix, vis_loy, vis_lox});

endmodule
